// ----- design/bgcd_pkg.sv -----
// Shared types, codes and constants of the bilinear grid current deposit unit.
package bgcd_pkg;

  localparam int GRID_N_DEFAULT = 128;
  localparam int GRID_N_MAX = 1024;
  localparam int IDX_W = $clog2(GRID_N_MAX + 1);
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [1:0] CMD_DEPOSIT = 2'd0;
  localparam logic [1:0] CMD_READ = 2'd1;
  localparam logic [1:0] CMD_WRITE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_X_ORIGIN = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_Z_ORIGIN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_X_SCALE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_Z_SCALE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_AREA_RECIP = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MIRROR = 3'd5;

  localparam logic [31:0] SCALE_RESET = 32'd65536;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_DEPOSIT,
    OP_READ,
    OP_WRITE
  } op_kind_t;

  typedef struct packed {
    logic signed [31:0] x_origin;
    logic signed [31:0] z_origin;
    logic [31:0] x_scale;
    logic [31:0] z_scale;
    logic [31:0] area_recip;
    logic mirror;
  } cfg_t;

  typedef struct packed {
    op_kind_t kind;
    logic [IDX_W-1:0] ix;
    logic [IDX_W-1:0] iz;
    logic mirror;
    logic [3:0][47:0] corner;
    logic [47:0] wval;
  } op_t;

  typedef struct packed {
    logic clearing;
  } back_status_t;

endpackage

// ----- design/bgcd_front.sv -----
// Front end: accepts transactions, classifies them and computes deposit weights.
module bgcd_front #(
  parameter int GRID_N = bgcd_pkg::GRID_N_DEFAULT
) (
  input  logic clk,
  input  logic rst,
  input  bgcd_pkg::cfg_t cfg,
  input  logic in_valid,
  output logic in_ready,
  input  logic [1:0] cmd,
  input  logic signed [31:0] x_pos,
  input  logic signed [31:0] z_pos,
  input  logic signed [31:0] coil_current,
  input  logic [15:0] current_fraction,
  input  logic coil_on,
  input  logic [7:0] grid_ix,
  input  logic [7:0] grid_iz,
  input  logic signed [47:0] write_value,
  output logic op_valid,
  input  logic op_ready,
  output bgcd_pkg::op_t op
);
  import bgcd_pkg::*;

  typedef enum logic [2:0] {
    F_IDLE, F_MX, F_MZ, F_Q, F_J, F_TX, F_C, F_PUSH
  } fstate_t;

  fstate_t state;
  logic signed [32:0] dx, dz;
  logic signed [31:0] coil_r;
  logic [15:0] frac_r;
  logic [15:0] fx, fz;
  logic okx;
  logic signed [31:0] q;
  logic signed [47:0] j;
  logic signed [47:0] t [2];
  logic [1:0] cnt;

  logic [63:0] px, pz;
  logic signed [47:0] pq;
  logic signed [63:0] pj, pt, pc;
  logic [16:0] wx, wz;
  logic [23:0] cell_x, cell_z;
  logic cell_x_ok, cell_z_ok;
  logic idx_ok;

  always_comb begin
    px = 64'(dx[31:0]) * 64'(cfg.x_scale);
    pz = 64'(dz[31:0]) * 64'(cfg.z_scale);
    cell_x = px[63:40];
    cell_z = pz[63:40];
    cell_x_ok = !dx[32] && (dx != 33'sd0) && (cell_x >= 24'd1) && (cell_x <= 24'(GRID_N - 1));
    cell_z_ok = !dz[32] && (dz != 33'sd0) && (cell_z >= 24'd1) && (cell_z <= 24'(GRID_N - 1));
    pq = coil_r * $signed({1'b0, frac_r});
    pj = q * $signed({1'b0, cfg.area_recip});
    wx = cnt[0] ? {1'b0, fx} : (17'h10000 - {1'b0, fx});
    wz = cnt[1] ? {1'b0, fz} : (17'h10000 - {1'b0, fz});
    pt = j * $signed({1'b0, wx});
    pc = t[cnt[0]] * $signed({1'b0, wz});
    idx_ok = (32'(grid_ix) <= 32'(GRID_N)) && (32'(grid_iz) <= 32'(GRID_N));
  end

  assign in_ready = (state == F_IDLE);
  assign op_valid = (state == F_PUSH);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
      cnt <= 2'd0;
    end else begin
      unique case (state)
        F_IDLE: begin
          if (in_valid) begin
            dx <= $signed({x_pos[31], x_pos}) - $signed({cfg.x_origin[31], cfg.x_origin});
            dz <= $signed({z_pos[31], z_pos}) - $signed({cfg.z_origin[31], cfg.z_origin});
            coil_r <= coil_current;
            frac_r <= current_fraction;
            op.ix <= IDX_W'(grid_ix);
            op.iz <= IDX_W'(grid_iz);
            op.wval <= write_value;
            op.mirror <= cfg.mirror;
            unique case (cmd)
              CMD_DEPOSIT: begin
                op.kind <= OP_NONE;
                state <= coil_on ? F_MX : F_PUSH;
              end
              CMD_READ: begin
                op.kind <= idx_ok ? OP_READ : OP_NONE;
                state <= F_PUSH;
              end
              CMD_WRITE: begin
                op.kind <= idx_ok ? OP_WRITE : OP_NONE;
                state <= F_PUSH;
              end
              default: begin
                op.kind <= OP_NONE;
                state <= F_PUSH;
              end
            endcase
          end
        end
        F_MX: begin
          op.ix <= px[40 +: IDX_W];
          fx <= px[39:24];
          okx <= cell_x_ok;
          state <= F_MZ;
        end
        F_MZ: begin
          op.iz <= pz[40 +: IDX_W];
          fz <= pz[39:24];
          state <= (okx && cell_z_ok) ? F_Q : F_PUSH;
        end
        F_Q: begin
          q <= pq[47:16];
          state <= F_J;
        end
        F_J: begin
          j <= pj[63:16];
          cnt <= 2'd0;
          state <= F_TX;
        end
        F_TX: begin
          t[cnt[0]] <= pt[63:16];
          cnt <= cnt + 2'd1;
          if (cnt[0]) begin
            cnt <= 2'd0;
            state <= F_C;
          end
        end
        F_C: begin
          op.corner[cnt] <= pc[63:16];
          cnt <= cnt + 2'd1;
          if (cnt == 2'd3) begin
            op.kind <= OP_DEPOSIT;
            state <= F_PUSH;
          end
        end
        F_PUSH: begin
          if (op_ready) begin
            state <= F_IDLE;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

endmodule

// ----- design/bgcd_queue.sv -----
// Two-entry queue that carries classified operations from front to back.
module bgcd_queue (
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  output logic push_ready,
  input  bgcd_pkg::op_t push_op,
  output logic pop_valid,
  input  logic pop_ready,
  output bgcd_pkg::op_t pop_op
);
  import bgcd_pkg::*;

  op_t slots [2];
  logic wr_ptr, rd_ptr;
  logic [1:0] count;
  logic do_push, do_pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid = (count != 2'd0);
  assign pop_op = slots[rd_ptr];
  assign do_push = push_valid && push_ready;
  assign do_pop = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_op;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule

// ----- design/bgcd_back.sv -----
// Back end: grid memory, clearing pass and read-modify-write sequencer.
module bgcd_back #(
  parameter int GRID_N = bgcd_pkg::GRID_N_DEFAULT
) (
  input  logic clk,
  input  logic rst,
  input  logic op_valid,
  output logic op_ready,
  input  bgcd_pkg::op_t op_in,
  output bgcd_pkg::back_status_t status,
  output logic out_valid,
  input  logic out_ready,
  output logic signed [47:0] read_value,
  output logic accepted
);
  import bgcd_pkg::*;

  localparam int SIDE = GRID_N + 1;
  localparam int DEPTH = SIDE * SIDE;
  localparam int ADDR_W = $clog2(DEPTH);

  typedef enum logic [2:0] {
    B_CLEAR, B_IDLE, B_RD, B_WR, B_DONE
  } bstate_t;

  bstate_t state;
  op_t cur;
  logic [2:0] step;
  logic [ADDR_W-1:0] clr;
  logic [47:0] mem [DEPTH];
  logic [47:0] rdata;
  logic [47:0] rv;

  logic a, b, rmw;
  logic [IDX_W-1:0] sx, sz, dz;
  logic [ADDR_W-1:0] raddr, waddr;
  logic we;
  logic [47:0] wdata;

  always_comb begin
    a = step[0];
    b = step[1];
    rmw = !step[2];
    sx = cur.ix + IDX_W'(a);
    sz = cur.iz + IDX_W'(b);
    dz = rmw ? sz : (IDX_W'(GRID_N) - cur.iz - IDX_W'(b));
    raddr = ADDR_W'(sx) * ADDR_W'(SIDE) + ADDR_W'(sz);
    we = 1'b0;
    waddr = ADDR_W'(sx) * ADDR_W'(SIDE) + ADDR_W'(dz);
    wdata = rdata;
    if (state == B_CLEAR) begin
      we = 1'b1;
      waddr = clr;
      wdata = 48'd0;
    end else if (state == B_WR) begin
      case (cur.kind)
        OP_DEPOSIT: begin
          we = 1'b1;
          wdata = rmw ? (rdata + cur.corner[step[1:0]]) : rdata;
        end
        OP_WRITE: begin
          we = 1'b1;
          wdata = cur.wval;
        end
        default: we = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  assign op_ready = (state == B_IDLE);
  assign status.clearing = (state == B_CLEAR);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_CLEAR;
      clr <= '0;
      step <= 3'd0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        B_CLEAR: begin
          clr <= clr + ADDR_W'(1);
          if (clr == ADDR_W'(DEPTH - 1)) begin
            state <= B_IDLE;
          end
        end
        B_IDLE: begin
          step <= 3'd0;
          rv <= 48'd0;
          if (op_valid) begin
            cur <= op_in;
            case (op_in.kind)
              OP_NONE: state <= B_DONE;
              OP_WRITE: state <= B_WR;
              default: state <= B_RD;
            endcase
          end
        end
        B_RD: state <= B_WR;
        B_WR: begin
          if (cur.kind == OP_READ) begin
            rv <= rdata;
            state <= B_DONE;
          end else if (cur.kind == OP_DEPOSIT) begin
            step <= step + 3'd1;
            if (step == 3'd7 || (step == 3'd3 && !cur.mirror)) begin
              state <= B_DONE;
            end else begin
              state <= B_RD;
            end
          end else begin
            state <= B_DONE;
          end
        end
        B_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            read_value <= rv;
            accepted <= (cur.kind != OP_NONE);
            state <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

endmodule

// ----- design/bilinear_grid_current_deposit_unit.sv -----
// Top level: configuration registers and the front, queue and back parts.
// Every transaction yields one result: a deposit (also a rejected one or one with the coil
// off), a read and a write. The front takes a new transaction once it has handed the last one
// to the queue, so it may work on the next while the back end is busy; a deposit takes four
// read-write pairs on the one grid port, or eight mirrored, and a read takes one.
// After reset a clearing pass zeroes all (GRID_N+1)^2 grid cells without accepting
// transactions; configuration writes are taken throughout.
module bilinear_grid_current_deposit_unit #(
  parameter int GRID_N = bgcd_pkg::GRID_N_DEFAULT
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [bgcd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bgcd_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic in_valid,
  output logic in_ready,
  input  logic [1:0] cmd,
  input  logic signed [31:0] x_pos,
  input  logic signed [31:0] z_pos,
  input  logic signed [31:0] coil_current,
  input  logic [15:0] current_fraction,
  input  logic coil_on,
  input  logic [7:0] grid_ix,
  input  logic [7:0] grid_iz,
  input  logic signed [47:0] write_value,
  output logic out_valid,
  input  logic out_ready,
  output logic signed [47:0] read_value,
  output logic accepted
);
  import bgcd_pkg::*;

  cfg_t cfg;
  logic front_ready;
  logic fq_valid, fq_ready, qb_valid, qb_ready;
  op_t fq_op, qb_op;
  back_status_t bstat;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.x_origin <= '0;
      cfg.z_origin <= '0;
      cfg.x_scale <= SCALE_RESET;
      cfg.z_scale <= SCALE_RESET;
      cfg.area_recip <= SCALE_RESET;
      cfg.mirror <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_X_ORIGIN: cfg.x_origin <= cfg_data;
        REG_Z_ORIGIN: cfg.z_origin <= cfg_data;
        REG_X_SCALE: cfg.x_scale <= cfg_data;
        REG_Z_SCALE: cfg.z_scale <= cfg_data;
        REG_AREA_RECIP: cfg.area_recip <= cfg_data;
        REG_MIRROR: cfg.mirror <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign in_ready = front_ready && !bstat.clearing;

  bgcd_front #(.GRID_N(GRID_N)) u_front (
    .clk(clk), .rst(rst), .cfg(cfg),
    .in_valid(in_valid && !bstat.clearing), .in_ready(front_ready),
    .cmd(cmd), .x_pos(x_pos), .z_pos(z_pos), .coil_current(coil_current),
    .current_fraction(current_fraction), .coil_on(coil_on),
    .grid_ix(grid_ix), .grid_iz(grid_iz), .write_value(write_value),
    .op_valid(fq_valid), .op_ready(fq_ready), .op(fq_op)
  );

  bgcd_queue u_queue (
    .clk(clk), .rst(rst),
    .push_valid(fq_valid), .push_ready(fq_ready), .push_op(fq_op),
    .pop_valid(qb_valid), .pop_ready(qb_ready), .pop_op(qb_op)
  );

  bgcd_back #(.GRID_N(GRID_N)) u_back (
    .clk(clk), .rst(rst),
    .op_valid(qb_valid), .op_ready(qb_ready), .op_in(qb_op), .status(bstat),
    .out_valid(out_valid), .out_ready(out_ready),
    .read_value(read_value), .accepted(accepted)
  );

endmodule
